[rtl/core/bpa_pkg.sv]
// bpa_pkg: item types, codes and fixed constants of the buddy page allocator.
// No dependencies; used by buddy_page_allocator_core and bpa_checker.
package bpa_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 2'd1;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_QRANK  = 2'd2;
    localparam logic [1:0] OP_QCOUNT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  req_rank;
        logic [31:0] req_address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_address;
        logic [10:0] answer;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_EXEC,
        S_REM_RD,
        S_REM_UPD,
        S_A_SCAN,
        S_A_SPLIT,
        S_A_PUSH1,
        S_A_PUSH2,
        S_A_FIN,
        S_Q_RANK,
        S_Q_COUNT,
        S_F_CHK,
        S_F_PUSH,
        S_F_LOOP,
        S_F_MCHK,
        S_F_M2,
        S_F_M3,
        S_F_M4
    } state_t;

endpackage

[rtl/core/buddy_page_allocator_core.sv]
// Buddy page allocator: sequencer around a page-info RAM, two link RAMs and
// per-rank free list registers. Depends on bpa_pkg.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one operation item;
//   out channel (out_valid/out_ready/out_data) gives exactly one result item
//   for each. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   base_address (index 0) or page_count (index 1); any known write
//   reinitializes the allocator to one free top-rank block. in_ready is held
//   low while cfg_valid is high, so a write never races an item.
// Operation: one item is worked at a time. Allocate scans up the ranks for
//   a free block, then splits it down to the wanted rank; every list removal
//   is a link RAM read then an update and the page RAM has one write port.
//   Free checks and pushes the block, then per merge reads the buddy page,
//   does two removals and two page writes, while the buddy is a free block
//   of the same rank, up to the top rank.
// Reset and config writes start a clearing pass over all MAX_PAGES page RAM
//   entries, one entry per cycle, during which in_ready stays low.
// The result sits in an output register; a new item is taken while it waits
//   only once the slot is free or being drained, so a stalled receiver
//   stalls the input after one pending result.
module buddy_page_allocator_core #(
    parameter int MAX_PAGES   = 1024,
    parameter int RANK_LEVELS = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  bpa_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bpa_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);
    import bpa_pkg::*;

    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int RW = (RANK_LEVELS > 1) ? $clog2(RANK_LEVELS) : 1;
    localparam int OW = 32 - PAGE_SHIFT;

    typedef struct packed {
        logic [RW-1:0] rank;
        logic          head;
        logic          free;
    } pent_t;

    function automatic logic [RW-1:0] f_top(input logic [10:0] pc);
        int k;
        k = 0;
        for (int i = 0; i < 17; i++)
        begin
            if (((1 << k) < int'(pc)) && (k < RANK_LEVELS - 1) &&
                ((1 << (k + 1)) <= MAX_PAGES))
                k++;
        end
        return RW'(k);
    endfunction

    localparam logic [10:0]   PC_RST  = 11'((MAX_PAGES < 1024) ? MAX_PAGES : 1024);
    localparam logic [RW-1:0] TOP_RST = f_top(PC_RST);

    // memories
    pent_t         page_mem [MAX_PAGES];
    logic [PW-1:0] link_next [MAX_PAGES];
    logic [PW-1:0] link_prev [MAX_PAGES];
    pent_t         pm_rd_reg;
    logic [PW-1:0] nx_rd_reg, pv_rd_reg;

    // free list heads
    logic [PW-1:0] first_reg [RANK_LEVELS];
    logic [PW-1:0] last_reg  [RANK_LEVELS];
    logic [PW:0]   size_reg  [RANK_LEVELS];

    state_t        state_reg, state_next, ret_reg, ret_next;
    in_item_t      in_reg, in_next;
    logic [RW-1:0] r_reg, r_next, want_reg, want_next, top_reg, top_next;
    logic [PW-1:0] pg_reg, pg_next, bp_reg, bp_next, rem_reg, rem_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [31:0]   base_reg, base_next;
    logic [10:0]   pc_reg, pc_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg, out_next;

    logic          pm_we;
    logic [PW-1:0] pm_wa, pm_ra, ln_ra;
    pent_t         pm_wd;
    logic          push_en, rem_en, list_init;
    logic [PW-1:0] push_pg;
    logic          nx_we, pv_we;
    logic [PW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

    logic          cfg_acc, in_acc, rank_ok;
    logic [31:0]   off;
    logic [OW-1:0] off_pg;
    logic          below_base;
    logic [PW-1:0] addr_pg;
    logic [PW-1:0] cur_first, cur_last;
    logic [PW:0]   cur_size;
    logic [10:0]   cfg_pc;

    assign cur_first = first_reg[r_reg];
    assign cur_last  = last_reg[r_reg];
    assign cur_size  = size_reg[r_reg];

    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid && (!out_valid_reg || out_ready);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign rank_ok    = (in_reg.req_rank != 4'd0) &&
                        ((32'(in_reg.req_rank) - 32'd1) <= 32'(top_reg));
    assign below_base = in_reg.req_address < base_reg;
    assign off        = in_reg.req_address - base_reg;
    assign off_pg     = off[31:PAGE_SHIFT];
    assign addr_pg    = PW'(off_pg);

    always_comb
    begin
        cfg_pc = cfg_data[10:0];
        if (cfg_pc == 11'd0)
            cfg_pc = 11'd1;
        if (32'(cfg_pc) > MAX_PAGES)
            cfg_pc = 11'(MAX_PAGES);
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        in_next        = in_reg;
        r_next         = r_reg;
        want_next      = want_reg;
        top_next       = top_reg;
        pg_next        = pg_reg;
        bp_next        = bp_reg;
        rem_next       = rem_reg;
        clr_next       = clr_reg;
        base_next      = base_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        pm_we          = 1'b0;
        pm_wa          = pg_reg;
        pm_wd          = '0;
        pm_ra          = pg_reg;
        ln_ra          = rem_reg;
        push_en        = 1'b0;
        push_pg        = pg_reg;
        rem_en         = 1'b0;
        list_init      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    in_next    = in_data;
                    state_next = S_EXEC;
                end
            end
            S_CLEAR:
            begin
                pm_we     = 1'b1;
                pm_wa     = clr_reg;
                pm_wd     = (clr_reg == '0) ? pent_t'{top_reg, 1'b1, 1'b1} : '0;
                list_init = (clr_reg == '0);
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == PW'(MAX_PAGES - 1))
                    state_next = S_IDLE;
            end
            S_EXEC:
            begin
                out_next   = '{status: ST_INVALID, block_address: '0, answer: '0};
                want_next  = RW'(in_reg.req_rank - 4'd1);
                r_next     = RW'(in_reg.req_rank - 4'd1);
                pg_next    = addr_pg;
                pm_ra      = addr_pg;
                state_next = S_IDLE;
                unique case (in_reg.opcode)
                    OP_ALLOC:
                        if (rank_ok) state_next = S_A_SCAN;
                    OP_FREE:
                        if (!below_base && off[PAGE_SHIFT-1:0] == '0 &&
                            off_pg <= OW'(pc_reg) - OW'(1))
                            state_next = S_F_CHK;
                    OP_QRANK:
                        if (!below_base && off_pg < OW'(pc_reg))
                            state_next = S_Q_RANK;
                    default:
                        if (rank_ok) state_next = S_Q_COUNT;
                endcase
                if (state_next == S_IDLE)
                    out_valid_next = 1'b1;
            end
            S_REM_RD:
            begin
                ln_ra      = rem_reg;
                state_next = S_REM_UPD;
            end
            S_REM_UPD:
            begin
                rem_en     = 1'b1;
                state_next = ret_reg;
            end
            S_A_SCAN:
            begin
                if (cur_size != '0)
                begin
                    pg_next    = cur_first;
                    rem_next   = cur_first;
                    ret_next   = (r_reg == want_reg) ? S_A_FIN : S_A_SPLIT;
                    state_next = S_REM_RD;
                end
                else if (r_reg == top_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next   = '{status: ST_NO_SPACE, block_address: '0, answer: '0};
                    state_next = S_IDLE;
                end
                else
                    r_next = r_reg + 1'b1;
            end
            S_A_SPLIT:
            begin
                r_next     = r_reg - 1'b1;
                bp_next    = pg_reg + (PW'(1) << (r_reg - 1'b1));
                pm_we      = 1'b1;
                pm_wa      = pg_reg;
                pm_wd      = pent_t'{r_reg - 1'b1, 1'b1, 1'b1};
                state_next = S_A_PUSH1;
            end
            S_A_PUSH1:
            begin
                pm_we      = 1'b1;
                pm_wa      = bp_reg;
                pm_wd      = pent_t'{r_reg, 1'b1, 1'b1};
                push_en    = 1'b1;
                push_pg    = pg_reg;
                state_next = S_A_PUSH2;
            end
            S_A_PUSH2:
            begin
                push_en    = 1'b1;
                push_pg    = bp_reg;
                rem_next   = pg_reg;
                ret_next   = (r_reg == want_reg) ? S_A_FIN : S_A_SPLIT;
                state_next = S_REM_RD;
            end
            S_A_FIN:
            begin
                pm_we          = 1'b1;
                pm_wa          = pg_reg;
                pm_wd          = pent_t'{want_reg, 1'b1, 1'b0};
                out_valid_next = 1'b1;
                out_next       = '{status: ST_OK,
                                   block_address: base_reg + (32'(pg_reg) << PAGE_SHIFT),
                                   answer: '0};
                state_next     = S_IDLE;
            end
            S_Q_RANK:
            begin
                out_valid_next = 1'b1;
                if (pm_rd_reg.head)
                    out_next = '{status: ST_OK, block_address: '0,
                                 answer: 11'(pm_rd_reg.rank) + 11'd1};
                else
                    out_next = '{status: ST_INVALID, block_address: '0, answer: '0};
                state_next = S_IDLE;
            end
            S_Q_COUNT:
            begin
                out_valid_next = 1'b1;
                out_next       = '{status: ST_OK, block_address: '0, answer: 11'(cur_size)};
                state_next     = S_IDLE;
            end
            S_F_CHK:
            begin
                if (!pm_rd_reg.head || pm_rd_reg.free)
                begin
                    out_valid_next = 1'b1;
                    out_next   = '{status: ST_INVALID, block_address: '0, answer: '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    r_next     = pm_rd_reg.rank;
                    pm_we      = 1'b1;
                    pm_wa      = pg_reg;
                    pm_wd      = pent_t'{pm_rd_reg.rank, 1'b1, 1'b1};
                    state_next = S_F_PUSH;
                end
            end
            S_F_PUSH:
            begin
                push_en    = 1'b1;
                push_pg    = pg_reg;
                state_next = S_F_LOOP;
            end
            S_F_LOOP:
            begin
                bp_next = pg_reg ^ (PW'(1) << r_reg);
                pm_ra   = pg_reg ^ (PW'(1) << r_reg);
                if (r_reg == top_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next   = '{status: ST_OK, block_address: '0, answer: '0};
                    state_next = S_IDLE;
                end
                else
                    state_next = S_F_MCHK;
            end
            S_F_MCHK:
            begin
                if (!pm_rd_reg.head || !pm_rd_reg.free || pm_rd_reg.rank != r_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next   = '{status: ST_OK, block_address: '0, answer: '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    rem_next   = pg_reg;
                    ret_next   = S_F_M2;
                    state_next = S_REM_RD;
                end
            end
            S_F_M2:
            begin
                rem_next   = bp_reg;
                ret_next   = S_F_M3;
                state_next = S_REM_RD;
            end
            S_F_M3:
            begin
                // the lower of the pair becomes the merged head
                pm_we      = 1'b1;
                pm_wa      = (pg_reg < bp_reg) ? bp_reg : pg_reg;
                pm_wd      = '0;
                pg_next    = (pg_reg < bp_reg) ? pg_reg : bp_reg;
                r_next     = r_reg + 1'b1;
                state_next = S_F_M4;
            end
            S_F_M4:
            begin
                pm_we      = 1'b1;
                pm_wa      = pg_reg;
                pm_wd      = pent_t'{r_reg, 1'b1, 1'b1};
                push_en    = 1'b1;
                push_pg    = pg_reg;
                state_next = S_F_LOOP;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cfg_acc && (cfg_index == CFG_BASE_ADDRESS || cfg_index == CFG_PAGE_COUNT))
        begin
            if (cfg_index == CFG_BASE_ADDRESS)
                base_next = cfg_data;
            else
                pc_next = cfg_pc;
            top_next   = f_top((cfg_index == CFG_PAGE_COUNT) ? cfg_pc : pc_reg);
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    // link RAM write-back for list push and removal
    always_comb
    begin
        nx_we = 1'b0;
        pv_we = 1'b0;
        nx_wa = cur_last;
        nx_wd = push_pg;
        pv_wa = push_pg;
        pv_wd = cur_last;
        if (push_en)
        begin
            nx_we = (cur_size != '0);
            pv_we = (cur_size != '0);
        end
        else if (rem_en && cur_size > (PW+1)'(1) &&
                 cur_first != rem_reg && cur_last != rem_reg)
        begin
            nx_we = 1'b1;
            nx_wa = pv_rd_reg;
            nx_wd = nx_rd_reg;
            pv_we = 1'b1;
            pv_wa = nx_rd_reg;
            pv_wd = pv_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
            page_mem[pm_wa] <= pm_wd;
        pm_rd_reg <= page_mem[pm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
            link_next[nx_wa] <= nx_wd;
        if (pv_we)
            link_prev[pv_wa] <= pv_wd;
        nx_rd_reg <= link_next[ln_ra];
        pv_rd_reg <= link_prev[ln_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RANK_LEVELS; i++)
                size_reg[i] <= '0;
        end
        else if (list_init)
        begin
            for (int i = 0; i < RANK_LEVELS; i++)
                size_reg[i] <= (RW'(i) == top_reg) ? (PW+1)'(1) : '0;
        end
        else if (push_en)
            size_reg[r_reg] <= cur_size + 1'b1;
        else if (rem_en && cur_size != '0)
            size_reg[r_reg] <= cur_size - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (list_init)
        begin
            first_reg[top_reg] <= '0;
            last_reg[top_reg]  <= '0;
        end
        else if (push_en)
        begin
            if (cur_size == '0)
                first_reg[r_reg] <= push_pg;
            last_reg[r_reg] <= push_pg;
        end
        else if (rem_en && cur_size > (PW+1)'(1))
        begin
            if (cur_first == rem_reg)
                first_reg[r_reg] <= nx_rd_reg;
            else if (cur_last == rem_reg)
                last_reg[r_reg] <= pv_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            base_reg      <= '0;
            pc_reg        <= PC_RST;
            top_reg       <= TOP_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            base_reg      <= base_next;
            pc_reg        <= pc_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg  <= ret_next;
        in_reg   <= in_next;
        r_reg    <= r_next;
        want_reg <= want_next;
        pg_reg   <= pg_next;
        bp_reg   <= bp_next;
        rem_reg  <= rem_next;
        out_reg  <= out_next;
    end

endmodule

[rtl/core/bpa_checker.sv]
// bpa_checker: port-level checks of buddy_page_allocator_core, bound below.
// Depends on bpa_pkg.
module bpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic                out_valid,
    input logic                out_ready,
    input bpa_pkg::out_item_t  out_data
);
    import bpa_pkg::*;

    // one item at a time: no second accept right after one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input ready right after a config write");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.block_address == '0 && out_data.answer == '0)
        else $error("failed item carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("unknown status code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (.*);
